>>> rtl/core/ctt_pkg.sv
// Shared types and constants for the connection tracking table.
`timescale 1ns / 1ps
package ctt_pkg;

   localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

   localparam logic [3:0] STYPE_STREAM   = 4'd1;
   localparam logic [3:0] STYPE_DATAGRAM = 4'd2;
   localparam logic [7:0] PROTO_ANY      = 8'd0;
   localparam logic [7:0] PROTO_TCP      = 8'd6;
   localparam logic [7:0] PROTO_UDP      = 8'd17;

   typedef enum logic [1:0] {
      OP_ADD        = 2'd0,
      OP_FIRST_SEND = 2'd1,
      OP_SET_MARK   = 2'd2,
      OP_TEST_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] handle;
      logic        tcp;
      logic        udp;
      logic        sent;
      logic        mark;
      logic [31:0] created;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/ctt_ctrl.sv
// Control state machine: clearing pass, item accept, table walk, commit.
`timescale 1ns / 1ps
module ctt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ctt_pkg::status_type status,
   output ctt_pkg::cmd_type    cmd
);
   import ctt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/core/ctt_datapath.sv
// Datapath: entry memory, table walk with aging and lookup, result register.
`timescale 1ns / 1ps
module ctt_datapath #(
   parameter int ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  ctt_pkg::cmd_type    cmd,
   output ctt_pkg::status_type status,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_socket_handle,
   input  logic [3:0]          req_sock_type,
   input  logic [7:0]          req_protocol,
   input  logic [31:0]         req_current_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic                rsp_is_tcp,
   output logic                rsp_is_udp,
   output logic                rsp_proxy_mark,
   output logic [31:0]         rsp_created_time,
   output logic                rsp_table_full,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_timeout_ms
);
   import ctt_pkg::*;

   localparam int IDXW = $clog2(ENTRIES);
   localparam logic [IDXW:0] CNT_END  = (IDXW+1)'(ENTRIES);
   localparam logic [IDXW:0] CNT_LAST = (IDXW+1)'(ENTRIES - 1);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   logic            mem_we;
   logic [IDXW-1:0] mem_waddr;
   entry_type       mem_wdata;
   logic            mem_re;

   logic [31:0]     timeout_ff;
   op_type          op_ff;
   logic [63:0]     key_ff;
   logic            tcp_ff;
   logic            udp_ff;
   logic [31:0]     now_ff;

   logic [IDXW:0]   cnt_ff, cnt_in;
   logic            eval_vld_ff, eval_vld_in;
   logic [IDXW-1:0] eval_idx_ff;
   logic            found_ff, found_in;
   logic [IDXW-1:0] match_idx_ff;
   entry_type       match_ff;
   logic            free_ff, free_in;
   logic [IDXW-1:0] free_idx_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            ok_ff, ok_in;
   logic            tcp_out_ff, tcp_out_in;
   logic            udp_out_ff, udp_out_in;
   logic            mark_out_ff, mark_out_in;
   logic [31:0]     created_out_ff, created_out_in;
   logic            full_ff, full_in;

   logic [31:0]     age;
   logic            expired;
   logic            live;
   logic            hit;
   entry_type       new_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[cnt_ff[IDXW-1:0]];
   end

   // evaluation of the entry read in the previous cycle
   assign age     = now_ff - rd_data_ff.created;
   assign expired = (op_ff == OP_ADD) && rd_data_ff.valid && (age > timeout_ff);
   assign live    = rd_data_ff.valid && !expired;
   assign hit     = live && (rd_data_ff.handle == key_ff);

   always_comb begin
      new_entry         = '0;
      new_entry.valid   = 1'b1;
      new_entry.handle  = key_ff;
      new_entry.tcp     = tcp_ff;
      new_entry.udp     = udp_ff;
      new_entry.created = now_ff;
   end

   always_comb begin
      mem_re      = cmd.scan && (cnt_ff != CNT_END);
      cnt_in      = cnt_ff;
      eval_vld_in = mem_re;
      found_in    = found_ff;
      free_in     = free_ff;
      mem_we      = 1'b0;
      mem_waddr   = eval_idx_ff;
      mem_wdata   = rd_data_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ok_in          = ok_ff;
      tcp_out_in     = tcp_out_ff;
      udp_out_in     = udp_out_ff;
      mark_out_in    = mark_out_ff;
      created_out_in = created_out_ff;
      full_in        = full_ff;

      if (cmd.start) begin
         cnt_in   = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
      end
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff[IDXW-1:0];
         mem_wdata = '0;
         cnt_in    = cnt_ff + 1'b1;
      end
      if (mem_re) cnt_in = cnt_ff + 1'b1;

      if (eval_vld_ff) begin
         if (expired) begin
            mem_we          = 1'b1;
            mem_wdata.valid = 1'b0;
         end
         if (hit) found_in = 1'b1;
         if (!live) free_in = 1'b1;
      end

      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         ok_in          = 1'b0;
         tcp_out_in     = 1'b0;
         udp_out_in     = 1'b0;
         mark_out_in    = 1'b0;
         created_out_in = '0;
         full_in        = 1'b0;
         mem_waddr      = match_idx_ff;
         mem_wdata      = match_ff;
         unique case (op_ff)
            OP_ADD: begin
               mem_wdata = new_entry;
               if (found_ff) begin
                  mem_we = 1'b1;
                  ok_in  = 1'b1;
               end else if (free_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = free_idx_ff;
                  ok_in     = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
            OP_FIRST_SEND: begin
               if (found_ff && !match_ff.sent) begin
                  mem_we         = 1'b1;
                  mem_wdata.sent = 1'b1;
                  ok_in          = 1'b1;
                  tcp_out_in     = match_ff.tcp;
                  udp_out_in     = match_ff.udp;
                  mark_out_in    = match_ff.mark;
                  created_out_in = match_ff.created;
               end
            end
            OP_SET_MARK: begin
               if (found_ff) begin
                  mem_we         = 1'b1;
                  mem_wdata.mark = 1'b1;
                  ok_in          = 1'b1;
               end
            end
            OP_TEST_CLEAR: begin
               if (found_ff && match_ff.mark) begin
                  mem_we         = 1'b1;
                  mem_wdata.mark = 1'b0;
                  ok_in          = 1'b1;
               end
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         cnt_ff       <= '0;
         eval_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) timeout_ff <= csr_timeout_ms;
         cnt_ff       <= cnt_in;
         eval_vld_ff  <= eval_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= op_type'(req_op);
         key_ff <= req_socket_handle;
         tcp_ff <= (req_sock_type == STYPE_STREAM) &&
                   ((req_protocol == PROTO_TCP) || (req_protocol == PROTO_ANY));
         udp_ff <= (req_sock_type == STYPE_DATAGRAM) &&
                   ((req_protocol == PROTO_UDP) || (req_protocol == PROTO_ANY));
         now_ff <= req_current_time;
      end
      eval_idx_ff <= cnt_ff[IDXW-1:0];
      // first live match and lowest free slot win
      if (eval_vld_ff && hit && !found_ff) begin
         match_idx_ff <= eval_idx_ff;
         match_ff     <= rd_data_ff;
      end
      if (eval_vld_ff && !live && !free_ff) free_idx_ff <= eval_idx_ff;
      ok_ff          <= ok_in;
      tcp_out_ff     <= tcp_out_in;
      udp_out_ff     <= udp_out_in;
      mark_out_ff    <= mark_out_in;
      created_out_ff <= created_out_in;
      full_ff        <= full_in;
   end

   assign status.clear_done = cmd.clear && (cnt_ff == CNT_LAST);
   assign status.scan_done  = (cnt_ff == CNT_END) && !eval_vld_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = ok_ff;
   assign rsp_is_tcp       = tcp_out_ff;
   assign rsp_is_udp       = udp_out_ff;
   assign rsp_proxy_mark   = mark_out_ff;
   assign rsp_created_time = created_out_ff;
   assign rsp_table_full   = full_ff;

endmodule

>>> rtl/core/connection_tracking_table.sv
// Top level of the connection tracking table.
//
// Tracks up to ENTRIES connections keyed by a 64-bit socket handle.
// req_* carries one transaction per item: add, first-send query, set proxy
// mark, or test-and-clear mark. rsp_* returns exactly one transaction per
// item, in order. csr_* writes timeout_ms; write it only while idle.
// Each item walks the whole table through the single read port of the
// entry memory, aging (on an add) and matching one entry per cycle, then
// commits with at most one write. One item is in flight at a time: the
// next is accepted only after the previous one commits.
// Reset is synchronous. After reset a clearing pass invalidates every
// entry; req_ready stays low until it ends, while csr writes are taken
// at once. timeout_ms resets to 30000.
// The result sits in an output register: the next item is accepted and
// walked while it waits, and only the commit of that next item holds
// until rsp_ready takes the pending result.
`timescale 1ns / 1ps
module connection_tracking_table #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_socket_handle,
   input  logic [3:0]  req_sock_type,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_current_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic        rsp_is_tcp,
   output logic        rsp_is_udp,
   output logic        rsp_proxy_mark,
   output logic [31:0] rsp_created_time,
   output logic        rsp_table_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_timeout_ms
);
   import ctt_pkg::*;

   cmd_type    cmd;
   status_type status;

   ctt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_op),
      .req_socket_handle (req_socket_handle),
      .req_sock_type     (req_sock_type),
      .req_protocol      (req_protocol),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_is_tcp        (rsp_is_tcp),
      .rsp_is_udp        (rsp_is_udp),
      .rsp_proxy_mark    (rsp_proxy_mark),
      .rsp_created_time  (rsp_created_time),
      .rsp_table_full    (rsp_table_full),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ms    (csr_timeout_ms)
   );

endmodule

>>> rtl/core/ctt_checker.sv
// Port-level checks for the connection tracking table, bound to the top level.
`timescale 1ns / 1ps
module ctt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic        rsp_is_tcp,
   input logic        rsp_is_udp,
   input logic        rsp_proxy_mark,
   input logic [31:0] rsp_created_time,
   input logic        rsp_table_full
);

   // a stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
      $stable(rsp_is_tcp) && $stable(rsp_is_udp) && $stable(rsp_proxy_mark) &&
      $stable(rsp_created_time) && $stable(rsp_table_full))
      else $error("result changed while stalled");

   // a dropped add never reports success
   a_full_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_ok && rsp_table_full))
      else $error("table_full together with ok");

   // classification is reported only on a granted first send
   a_class_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_tcp || rsp_is_udp || rsp_proxy_mark) |->
      rsp_ok && !rsp_table_full)
      else $error("entry fields without a grant");

   a_class_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_tcp && rsp_is_udp))
      else $error("entry both tcp and udp");

   // the table walk keeps the request side closed after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted during a walk");

endmodule

bind connection_tracking_table ctt_checker u_ctt_checker (.*);

>>> dv/ctt_checker.sv
// Checker for the connection tracking table: predicts each response and compares it.
`timescale 1ns / 1ps
module ctt_scoreboard #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_socket_handle,
   input  logic [3:0]  req_sock_type,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_current_time,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_ok,
   input  logic        rsp_is_tcp,
   input  logic        rsp_is_udp,
   input  logic        rsp_proxy_mark,
   input  logic [31:0] rsp_created_time,
   input  logic        rsp_table_full,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_timeout_ms,
   output int          mismatches,
   output int          outstanding,
   output int          items_taken,
   output int          results_checked,
   output int          full_drops,
   output int          grants
);
   import ctt_pkg::*;

   typedef struct packed {
      logic        ok;
      logic        is_tcp;
      logic        is_udp;
      logic        proxy_mark;
      logic [31:0] created_time;
      logic        table_full;
   } outcome_type;

   // mirror of the table
   logic        slot_live   [ENTRIES];
   logic [63:0] slot_handle [ENTRIES];
   logic        slot_tcp    [ENTRIES];
   logic        slot_udp    [ENTRIES];
   logic        slot_sent   [ENTRIES];
   logic        slot_mark   [ENTRIES];
   logic [31:0] slot_born   [ENTRIES];
   logic [31:0] timeout_cur;

   outcome_type expected_outcomes[$];

   function automatic outcome_type apply_request(op_type op, logic [63:0] key,
                                                 logic [3:0] stype, logic [7:0] proto,
                                                 logic [31:0] now);
      outcome_type r;
      int hit;
      logic [31:0] age;
      r = '0;
      hit = -1;
      if (op == OP_ADD) begin
         for (int i = 0; i < ENTRIES; i++) begin
            age = now - slot_born[i];
            if (slot_live[i] && age > timeout_cur)
               slot_live[i] = 1'b0;
         end
      end
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && slot_live[i] && slot_handle[i] == key)
            hit = i;
      case (op)
         OP_ADD: begin
            for (int i = 0; i < ENTRIES; i++)
               if (hit < 0 && !slot_live[i])
                  hit = i;
            if (hit < 0) begin
               r.table_full = 1'b1;
            end else begin
               slot_live[hit]   = 1'b1;
               slot_handle[hit] = key;
               slot_tcp[hit]    = (stype == STYPE_STREAM) &&
                                  (proto == PROTO_TCP || proto == PROTO_ANY);
               slot_udp[hit]    = (stype == STYPE_DATAGRAM) &&
                                  (proto == PROTO_UDP || proto == PROTO_ANY);
               slot_sent[hit]   = 1'b0;
               slot_mark[hit]   = 1'b0;
               slot_born[hit]   = now;
               r.ok = 1'b1;
            end
         end
         OP_FIRST_SEND: begin
            if (hit >= 0 && !slot_sent[hit]) begin
               slot_sent[hit] = 1'b1;
               r.ok           = 1'b1;
               r.is_tcp       = slot_tcp[hit];
               r.is_udp       = slot_udp[hit];
               r.proxy_mark   = slot_mark[hit];
               r.created_time = slot_born[hit];
            end
         end
         OP_SET_MARK: begin
            if (hit >= 0) begin
               slot_mark[hit] = 1'b1;
               r.ok = 1'b1;
            end
         end
         default: begin
            if (hit >= 0 && slot_mark[hit]) begin
               slot_mark[hit] = 1'b0;
               r.ok = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i]   = 1'b0;
            slot_handle[i] = '0;
            slot_tcp[i]    = 1'b0;
            slot_udp[i]    = 1'b0;
            slot_sent[i]   = 1'b0;
            slot_mark[i]   = 1'b0;
            slot_born[i]   = '0;
         end
         timeout_cur = TIMEOUT_RESET;
         expected_outcomes.delete();
         mismatches      <= 0;
         items_taken     <= 0;
         results_checked <= 0;
         full_drops      <= 0;
         grants          <= 0;
      end else begin
         if (csr_valid && csr_ready)
            timeout_cur = csr_timeout_ms;
         // older transaction first: a response can never belong to a request taken this edge
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_ok, rsp_is_tcp, rsp_is_udp, rsp_proxy_mark,
                    rsp_created_time, rsp_table_full};
            results_checked <= results_checked + 1;
            if (expected_outcomes.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%0t: response with nothing expected: ok=%0b tcp=%0b udp=%0b",
                           $realtime, seen.ok, seen.is_tcp, seen.is_udp);
            end else begin
               want = expected_outcomes.pop_front();
               if (seen !== want) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"%0t: mismatch: expected ok=%0b tcp=%0b udp=%0b mark=%0b ",
                               "created=%08h full=%0b, got ok=%0b tcp=%0b udp=%0b mark=%0b ",
                               "created=%08h full=%0b"}, $realtime,
                              want.ok, want.is_tcp, want.is_udp, want.proxy_mark,
                              want.created_time, want.table_full,
                              seen.ok, seen.is_tcp, seen.is_udp, seen.proxy_mark,
                              seen.created_time, seen.table_full);
               end
               if (want.table_full)
                  full_drops <= full_drops + 1;
            end
         end
         if (req_valid && req_ready) begin
            want = apply_request(op_type'(req_op), req_socket_handle, req_sock_type,
                                 req_protocol, req_current_time);
            expected_outcomes.insert(expected_outcomes.size(), want);
            items_taken <= items_taken + 1;
            if (op_type'(req_op) == OP_FIRST_SEND && want.ok)
               grants <= grants + 1;
         end
      end
      outstanding <= expected_outcomes.size();
   end

endmodule

>>> dv/tb_connection_tracking_table.sv
// Testbench top for the connection tracking table: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_connection_tracking_table;
   import ctt_pkg::*;

   localparam int ENTRIES    = 64;
   localparam int POOL_SIZE  = 100;
   localparam int PHASE_ITEMS = 150;

   localparam logic [63:0] H_ZERO = 64'h0;
   localparam logic [63:0] H_ONES = '1;
   localparam logic [63:0] H_A    = 64'hA5A5_A5A5_A5A5_A5A5;
   localparam logic [63:0] H_B    = 64'h5A5A_5A5A_5A5A_5A5A;
   localparam logic [63:0] H_C    = 64'h8000_0000_0000_0001;
   localparam logic [63:0] H_D    = 64'h7FFF_FFFF_FFFF_FFFE;
   localparam logic [63:0] H_E    = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] H_ONE  = 64'h1;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [63:0] req_socket_handle;
   logic [3:0]  req_sock_type;
   logic [7:0]  req_protocol;
   logic [31:0] req_current_time;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic        rsp_is_tcp;
   logic        rsp_is_udp;
   logic        rsp_proxy_mark;
   logic [31:0] rsp_created_time;
   logic        rsp_table_full;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_timeout_ms;

   int mismatches;
   int outstanding;
   int items_taken;
   int results_checked;
   int full_drops;
   int grants;

   int idle_pct  = 0;
   int stall_pct = 0;
   int stall_left = 0;

   logic [63:0] handle_pool [POOL_SIZE];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   connection_tracking_table #(.ENTRIES(ENTRIES)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_socket_handle (req_socket_handle),
      .req_sock_type     (req_sock_type),
      .req_protocol      (req_protocol),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_is_tcp        (rsp_is_tcp),
      .rsp_is_udp        (rsp_is_udp),
      .rsp_proxy_mark    (rsp_proxy_mark),
      .rsp_created_time  (rsp_created_time),
      .rsp_table_full    (rsp_table_full),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ms    (csr_timeout_ms)
   );

   ctt_scoreboard #(.ENTRIES(ENTRIES)) u_scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_socket_handle (req_socket_handle),
      .req_sock_type     (req_sock_type),
      .req_protocol      (req_protocol),
      .req_current_time  (req_current_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ok            (rsp_ok),
      .rsp_is_tcp        (rsp_is_tcp),
      .rsp_is_udp        (rsp_is_udp),
      .rsp_proxy_mark    (rsp_proxy_mark),
      .rsp_created_time  (rsp_created_time),
      .rsp_table_full    (rsp_table_full),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ms    (csr_timeout_ms),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .items_taken       (items_taken),
      .results_checked   (results_checked),
      .full_drops        (full_drops),
      .grants            (grants)
   );

   // response backpressure: per-cycle stalls plus an occasional long one
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(63) == 0) begin
         stall_left <= $urandom_range(1, 100);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(op_type op, logic [63:0] key, logic [3:0] stype,
                               logic [7:0] proto, logic [31:0] stamp);
      int gap;
      req_valid         <= 1'b1;
      req_op            <= op;
      req_socket_handle <= key;
      req_sock_type     <= stype;
      req_protocol      <= proto;
      req_current_time  <= stamp;
      do @(posedge clock); while (!req_ready);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         // mostly short gaps, some long enough to land anywhere in the table walk
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 2 * ENTRIES + 10)
                                        : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] value);
      csr_valid      <= 1'b1;
      csr_timeout_ms <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [63:0] key;
      logic [63:0] last_key;
      logic [31:0] now;
      logic [3:0]  stype;
      logic [7:0]  proto;
      logic [31:0] stamp;
      op_type      op;
      int          r;
      int          add_pct;
      int          span;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_ADD;
      req_socket_handle = '0;
      req_sock_type     = '0;
      req_protocol      = '0;
      req_current_time  = '0;
      csr_valid         = 1'b0;
      csr_timeout_ms    = '0;

      handle_pool[0] = H_ZERO;
      handle_pool[1] = H_ONES;
      for (int i = 2; i < POOL_SIZE; i++)
         handle_pool[i] = {$urandom, $urandom};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: absent handles, every class, grant once, marks, overwrite, expiry, wrap
      send_request(OP_FIRST_SEND, H_ZERO, 4'd0, 8'd0, 32'd0);
      send_request(OP_SET_MARK,   H_ZERO, 4'd0, 8'd0, 32'd0);
      send_request(OP_TEST_CLEAR, H_ZERO, 4'd0, 8'd0, 32'd0);
      send_request(OP_ADD, H_ZERO, STYPE_STREAM,   PROTO_TCP, 32'd0);
      send_request(OP_ADD, H_ONES, STYPE_DATAGRAM, PROTO_UDP, 32'd0);
      send_request(OP_ADD, H_A,    STYPE_STREAM,   PROTO_ANY, 32'd5);
      send_request(OP_ADD, H_B,    STYPE_DATAGRAM, PROTO_ANY, 32'd5);
      send_request(OP_ADD, H_C,    STYPE_STREAM,   PROTO_UDP, 32'd5);
      send_request(OP_ADD, H_D,    4'hF,           8'hFF,     32'd5);
      send_request(OP_FIRST_SEND, H_ZERO, 4'd0, 8'd0, 32'd0);
      send_request(OP_FIRST_SEND, H_ZERO, 4'hF, 8'hFF, '1);
      send_request(OP_SET_MARK,   H_ONES, 4'd0, 8'd0, 32'd0);
      send_request(OP_FIRST_SEND, H_ONES, 4'd0, 8'd0, 32'd0);
      send_request(OP_TEST_CLEAR, H_ONES, 4'd0, 8'd0, 32'd0);
      send_request(OP_TEST_CLEAR, H_ONES, 4'd0, 8'd0, 32'd0);
      // age exactly at the timeout survives; the present handle is overwritten
      send_request(OP_ADD, H_ZERO, STYPE_DATAGRAM, PROTO_ANY, TIMEOUT_RESET);
      send_request(OP_FIRST_SEND, H_ZERO, 4'd0, 8'd0, 32'd0);
      send_request(OP_ADD, H_E, STYPE_STREAM, PROTO_TCP, TIMEOUT_RESET + 32'd6);
      send_request(OP_FIRST_SEND, H_A, 4'd0, 8'd0, 32'd0);
      // time goes backward: older entries look ahead and wrap to a huge age
      send_request(OP_ADD, H_ONE, 4'd0, PROTO_ANY, 32'd100);
      send_request(OP_FIRST_SEND, H_ZERO, 4'd0, 8'd0, 32'd0);
      send_request(OP_FIRST_SEND, H_ONE, 4'd0, 8'd0, 32'd0);
      send_request(OP_ADD, H_ONES, STYPE_DATAGRAM, PROTO_TCP, '1);
      // wrap of the clock itself keeps a young entry
      send_request(OP_ADD, H_A, STYPE_STREAM, PROTO_ANY, 32'h10);
      send_request(OP_FIRST_SEND, H_ONES, 4'd0, 8'd0, 32'd0);

      last_key = H_A;
      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         case (phase)
            0: begin
               write_timeout('1);
               idle_pct = 0;  stall_pct = 0;  add_pct = 80; span = POOL_SIZE;
            end
            1: begin
               write_timeout(32'd0);
               idle_pct = 45; stall_pct = 0;  add_pct = 35; span = 24;
            end
            2: begin
               write_timeout(TIMEOUT_RESET);
               idle_pct = 0;  stall_pct = 45; add_pct = 35; span = 24;
            end
            default: begin
               r = $urandom_range(2);
               write_timeout(r == 0 ? $urandom_range(0, 1000) :
                             r == 1 ? $urandom_range(1000, 100000) : $urandom);
               idle_pct = 25; stall_pct = 25; add_pct = 35; span = 24;
            end
         endcase
         now = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 25)
               ;
            else if (r < 65)
               now = now + $urandom_range(1, 200);
            else if (r < 90)
               now = now + $urandom_range(1000, 40000);
            else if (r < 95)
               now = now + $urandom;
            else
               now = now - $urandom_range(1, 500);

            if ($urandom_range(99) < add_pct) begin
               op = OP_ADD;
            end else begin
               case ($urandom_range(2))
                  0:       op = OP_FIRST_SEND;
                  1:       op = OP_SET_MARK;
                  default: op = OP_TEST_CLEAR;
               endcase
            end

            r = $urandom_range(99);
            if (r < 30)
               key = last_key;
            else if (r < 90)
               key = handle_pool[$urandom_range(span - 1)];
            else
               key = {$urandom, $urandom};

            if (op == OP_ADD) begin
               r = $urandom_range(99);
               stype = (r < 40) ? STYPE_STREAM : (r < 80) ? STYPE_DATAGRAM : 4'($urandom);
               r = $urandom_range(99);
               proto = (r < 30) ? PROTO_ANY : (r < 55) ? PROTO_TCP :
                       (r < 80) ? PROTO_UDP : 8'($urandom);
               stamp = now;
               last_key = key;
            end else begin
               stype = 4'($urandom);
               proto = 8'($urandom);
               stamp = $urandom;
            end
            send_request(op, key, stype, proto, stamp);
            if ($urandom_range(39) == 0)
               drain_responses();
         end
      end

      drain_responses();
      repeat (ENTRIES + 8) @(posedge clock);

      $display("run covered %0d requests and %0d checked responses, %0d first-send grants,",
               items_taken, results_checked, grants);
      $display("%0d table-full drops, timeouts at reset value, zero, maximum and random",
               full_drops);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_connection_tracking_table: clean");
      end else begin
         $display("tb_connection_tracking_table: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("tb_connection_tracking_table: errors");
      $finish;
   end

endmodule
